// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL that checks itself.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ----- sv/dpf_pkg.sv -----
// Types and constants of the detector pulse frame parser.
// Used by dpf_step and detector_pulse_frame_parser_top; depends on nothing.
`default_nettype none
package dpf_pkg;

	localparam int unsigned PhaseW = 6;

	// Parser phases: each names the byte the parser waits for next.
	localparam logic [PhaseW-1:0] PH_IDLE      = 6'd0;
	localparam logic [PhaseW-1:0] PH_HDR_FIRST = 6'd1;
	localparam logic [PhaseW-1:0] PH_HDR_F7    = 6'd7;
	localparam logic [PhaseW-1:0] PH_T0_B0     = 6'd8;
	localparam logic [PhaseW-1:0] PH_T0_B1     = 6'd9;
	localparam logic [PhaseW-1:0] PH_T0_B2     = 6'd10;
	localparam logic [PhaseW-1:0] PH_T0_B3     = 6'd11;
	localparam logic [PhaseW-1:0] PH_RSV_B0    = 6'd12;
	localparam logic [PhaseW-1:0] PH_RSV_B1    = 6'd13;
	localparam logic [PhaseW-1:0] PH_RSV_B2    = 6'd14;
	localparam logic [PhaseW-1:0] PH_RSV_B3    = 6'd15;
	localparam logic [PhaseW-1:0] PH_HDR_LAST  = 6'd16;
	localparam logic [PhaseW-1:0] PH_HIT_FIRST = 6'd17;
	localparam logic [PhaseW-1:0] PH_HIT_B2    = 6'd18;
	localparam logic [PhaseW-1:0] PH_HIT_B3    = 6'd19;
	localparam logic [PhaseW-1:0] PH_HIT_LAST  = 6'd20;
	localparam logic [PhaseW-1:0] PH_POP_FIRST = 6'd21;
	localparam logic [PhaseW-1:0] PH_POP_B2    = 6'd22;
	localparam logic [PhaseW-1:0] PH_POP_B3    = 6'd23;
	localparam logic [PhaseW-1:0] PH_POP_LAST  = 6'd24;
	localparam logic [PhaseW-1:0] PH_END_FIRST = 6'd25;
	localparam logic [PhaseW-1:0] PH_END_B2    = 6'd26;
	localparam logic [PhaseW-1:0] PH_END_B3    = 6'd27;
	localparam logic [PhaseW-1:0] PH_CNT_B0    = 6'd28;
	localparam logic [PhaseW-1:0] PH_CNT_B1    = 6'd29;
	localparam logic [PhaseW-1:0] PH_CNT_B2    = 6'd30;
	localparam logic [PhaseW-1:0] PH_CNT_B3    = 6'd31;
	localparam logic [PhaseW-1:0] PH_END_LAST  = 6'd32;
	localparam logic [PhaseW-1:0] PH_ERROR     = 6'd33;

	// Marker bytes.
	localparam logic [7:0] BYTE_FRAME_START = 8'hFA;
	localparam logic [7:0] BYTE_POP_START   = 8'hF0;
	localparam logic [7:0] BYTE_END_START   = 8'hFB;

	localparam logic [31:0] HDR_BYTES  = 32'd16;
	localparam logic [31:0] WORD_BYTES = 32'd4;

	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic [31:0]       acc;
		logic [31:0]       count;
	} parse_state_t;

endpackage
`default_nettype wire

// ----- sv/dpf_step.sv -----
// Next-state logic of the frame parser: one byte against the current state.
// Depends on dpf_pkg.
`default_nettype none
module dpf_step import dpf_pkg::*; (
	input  wire parse_state_t cur,
	input  wire logic [7:0]   data_byte,
	output parse_state_t      nxt
);

	logic [PhaseW-1:0] phase_inc;
	logic [31:0]       count_inc;

	assign phase_inc = cur.phase + 1'b1;
	assign count_inc = cur.count + WORD_BYTES;

	always_comb begin
		nxt = cur;
		case (cur.phase) inside
			PH_IDLE, PH_END_LAST: begin
				nxt.phase = (data_byte == BYTE_FRAME_START) ? PH_HDR_FIRST : PH_IDLE;
			end
			[PH_HDR_FIRST:PH_HDR_F7]: begin
				nxt.acc   = {24'd0, data_byte};
				nxt.phase = phase_inc;
			end
			PH_T0_B0, PH_RSV_B0, PH_CNT_B0: begin
				nxt.acc   = {data_byte, 24'd0};
				nxt.phase = phase_inc;
			end
			PH_T0_B1, PH_RSV_B1, PH_CNT_B1: begin
				nxt.acc   = cur.acc | {8'd0, data_byte, 16'd0};
				nxt.phase = phase_inc;
			end
			PH_T0_B2, PH_RSV_B2, PH_CNT_B2, PH_HIT_B2, PH_END_B2: begin
				nxt.acc   = cur.acc | {16'd0, data_byte, 8'd0};
				nxt.phase = phase_inc;
			end
			PH_T0_B3, PH_CNT_B3: begin
				nxt.acc   = cur.acc | {24'd0, data_byte};
				nxt.phase = phase_inc;
			end
			PH_RSV_B3: begin
				nxt.acc   = cur.acc | {24'd0, data_byte};
				nxt.phase = PH_HDR_LAST;
				nxt.count = HDR_BYTES;
			end
			PH_HDR_LAST, PH_HIT_LAST: begin
				// The opening byte of a hit is kept; marker bytes clear the field.
				if (data_byte == BYTE_POP_START) begin
					nxt.acc   = '0;
					nxt.phase = PH_POP_FIRST;
				end else if (data_byte == BYTE_END_START) begin
					nxt.acc   = '0;
					nxt.phase = PH_END_FIRST;
				end else begin
					nxt.acc   = {24'd0, data_byte};
					nxt.phase = PH_HIT_FIRST;
				end
			end
			PH_HIT_FIRST, PH_END_FIRST: begin
				nxt.acc   = {8'd0, data_byte, 16'd0};
				nxt.phase = phase_inc;
			end
			PH_HIT_B3, PH_END_B3: begin
				nxt.acc   = cur.acc | {24'd0, data_byte};
				nxt.phase = phase_inc;
				nxt.count = count_inc;
			end
			PH_POP_FIRST, PH_POP_B2: begin
				nxt.phase = phase_inc;
			end
			PH_POP_B3: begin
				nxt.phase = PH_POP_LAST;
				nxt.count = count_inc;
			end
			PH_POP_LAST: begin
				nxt.phase = (data_byte == BYTE_END_START) ? PH_END_FIRST : PH_ERROR;
			end
			default: begin
				// Error and unused phase codes drop back to idle on any byte.
				nxt.phase = PH_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/detector_pulse_frame_parser_top.sv -----
// Detector pulse frame parser: input byte register, step logic, result register.
// Depends on dpf_pkg, dpf_step and assert_macros.svh.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+-------------------------------
//   in      | in_valid / in_stall        | data_byte[7:0]
//   out     | out_valid / out_stall      | value[31:0], phase[5:0], byte_count[31:0]
//
// One byte is accepted per cycle while in_stall is low, into the input byte register; its
// parsed result is registered in the result register. The parser state is that register
// itself, so throughput is set by the combinational step from the input register into it.
// arst_n clears the phase, accumulator, byte count and both valid flags.
// in_stall rises only while both stages are full and out_stall holds the result.
`default_nettype none
`include "assert_macros.svh"
module detector_pulse_frame_parser_top import dpf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        data_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [31:0]            value,
	output logic [PhaseW-1:0]      phase,
	output logic [31:0]            byte_count
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         adv_out;
	logic         take_in;

	assign adv_out  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_out;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= data_byte;
		end
	end

	dpf_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.nxt       (state_nxt)
	);

	// The state moves only when a transaction leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q     <= '{phase: PH_IDLE, acc: '0, count: '0};
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = state_q.acc;
	assign phase      = state_q.phase;
	assign byte_count = state_q.count;

	`ASSERT_CLK(a_phase_range, clk, arst_n, state_q.phase <= PH_ERROR, "phase beyond error code")
	`ASSERT_CLK(a_hdr_count, clk, arst_n, (state_q.phase == PH_HDR_LAST) |-> (state_q.count == HDR_BYTES), "header end without count of 16")
	`ASSERT_CLK(a_stall_full, clk, arst_n, in_stall |-> (valid_s1 && out_valid_q && out_stall), "input stalled with room in the pipeline")
	`ASSERT_CLK(a_err_from_pop, clk, arst_n, (state_q.phase == PH_ERROR && $past(state_q.phase) != PH_ERROR) |-> ($past(state_q.phase) == PH_POP_LAST), "error not after a pop block")

endmodule
`default_nettype wire

// ----- test/tb_detector_pulse_frame_parser_top.sv -----
// Self-checking testbench for detector_pulse_frame_parser_top: byte streams of pulse
// frames go in and every result is checked against a predictor. Depends on dpf_pkg
// and the parser RTL only.
module tb_detector_pulse_frame_parser_top;
	import dpf_pkg::*;

	localparam int unsigned BYTE_TARGET = 1400;
	localparam int unsigned IDLE_PCT    = 14;
	localparam int unsigned QUIET_FROM  = 300;
	localparam int unsigned QUIET_TO    = 650;
	localparam int unsigned HOLD_AT     = 900;
	localparam int unsigned HOLD_LEN    = 90;
	localparam int unsigned DRAIN_LIMIT = 2000;

	typedef struct packed {
		logic [31:0]       value;
		logic [PhaseW-1:0] phase;
		logic [31:0]       count;
	} frame_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic [7:0]        data_byte = 8'h00;
	logic              out_stall = 1'b0;
	logic              in_stall;
	logic              out_valid;
	logic [31:0]       value;
	logic [PhaseW-1:0] phase;
	logic [31:0]       byte_count;

	logic [7:0]    byte_q[$];
	frame_result_t result_q[$];
	int unsigned   bytes_queued = 0;
	int unsigned   bytes_taken = 0;
	int unsigned   results_seen = 0;
	int unsigned   mismatches = 0;
	int unsigned   cyc = 0;
	int unsigned   hold_left = 0;
	int unsigned   stall_cycles = 0;
	logic          quiet;

	// Predictor state and what it saw.
	logic [PhaseW-1:0] track_phase = PH_IDLE;
	logic [31:0]       track_word = '0;
	logic [31:0]       track_count = '0;
	int unsigned       n_frames = 0;
	int unsigned       n_hits = 0;
	int unsigned       n_pops = 0;
	int unsigned       n_ends = 0;
	int unsigned       n_broken = 0;

	detector_pulse_frame_parser_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.phase      (phase),
		.byte_count (byte_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

	// Advances the parser by one byte and queues the result it must report.
	function automatic void parse_byte(input logic [7:0] b);
		case (track_phase)
			PH_IDLE, PH_END_LAST: begin
				if (b == BYTE_FRAME_START) begin
					track_phase = PH_HDR_FIRST;
					n_frames++;
				end else begin
					track_phase = PH_IDLE;
				end
			end
			PH_T0_B0, PH_RSV_B0, PH_CNT_B0: begin
				track_word = {b, 24'h0};
				track_phase = track_phase + 1'b1;
			end
			PH_T0_B1, PH_RSV_B1, PH_CNT_B1: begin
				track_word |= {8'h0, b, 16'h0};
				track_phase = track_phase + 1'b1;
			end
			PH_T0_B2, PH_RSV_B2, PH_CNT_B2, PH_HIT_B2, PH_END_B2: begin
				track_word |= {16'h0, b, 8'h0};
				track_phase = track_phase + 1'b1;
			end
			PH_T0_B3, PH_CNT_B3: begin
				track_word |= {24'h0, b};
				track_phase = track_phase + 1'b1;
			end
			PH_RSV_B3: begin
				track_word |= {24'h0, b};
				track_phase = PH_HDR_LAST;
				track_count = HDR_BYTES;
			end
			PH_HDR_LAST, PH_HIT_LAST: begin
				track_word = '0;
				if (b == BYTE_POP_START) begin
					track_phase = PH_POP_FIRST;
				end else if (b == BYTE_END_START) begin
					track_phase = PH_END_FIRST;
				end else begin
					track_word = {24'h0, b};
					track_phase = PH_HIT_FIRST;
				end
			end
			PH_HIT_FIRST, PH_END_FIRST: begin
				track_word = {8'h0, b, 16'h0};
				track_phase = track_phase + 1'b1;
			end
			PH_HIT_B3, PH_END_B3: begin
				if (track_phase == PH_HIT_B3) n_hits++;
				else n_ends++;
				track_word |= {24'h0, b};
				track_phase = track_phase + 1'b1;
				track_count = track_count + WORD_BYTES;
			end
			PH_POP_FIRST, PH_POP_B2: begin
				track_phase = track_phase + 1'b1;
			end
			PH_POP_B3: begin
				track_phase = PH_POP_LAST;
				track_count = track_count + WORD_BYTES;
				n_pops++;
			end
			PH_POP_LAST: begin
				if (b == BYTE_END_START) begin
					track_phase = PH_END_FIRST;
				end else begin
					track_phase = PH_ERROR;
					n_broken++;
				end
			end
			default: begin
				// Single-byte header fields; the error phase and unused codes fall to idle.
				if (track_phase >= PH_HDR_FIRST && track_phase <= PH_HDR_F7) begin
					track_word = {24'h0, b};
					track_phase = track_phase + 1'b1;
				end else begin
					track_phase = PH_IDLE;
				end
			end
		endcase
		result_q.push_back('{value: track_word, phase: track_phase, count: track_count});
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got,
			want);
		mismatches++;
	endtask

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		byte_q.push_back(b);
		bytes_queued++;
	endfunction

	function automatic void push_header();
		push_byte(BYTE_FRAME_START);
		repeat (15) push_byte(rnd_byte());
	endfunction

	function automatic void push_hit();
		logic [7:0] opener;
		opener = rnd_byte();
		while (opener == BYTE_POP_START || opener == BYTE_END_START) opener = rnd_byte();
		push_byte(opener);
		repeat (3) push_byte(rnd_byte());
	endfunction

	function automatic void push_pop();
		push_byte(BYTE_POP_START);
		repeat (3) push_byte(rnd_byte());
	endfunction

	function automatic void push_end_block();
		push_byte(BYTE_END_START);
		repeat (7) push_byte(rnd_byte());
	endfunction

	// Sender: a new transaction is offered once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
		end else begin
			if (in_valid && in_stall) stall_cycles++;
			if (in_valid && !in_stall) begin
				parse_byte(data_byte);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (byte_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					data_byte <= byte_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Cycle count and the long output hold-off that fills the pipeline.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc <= 0;
			hold_left <= 0;
		end else begin
			cyc <= cyc + 1;
			if (cyc == HOLD_AT) hold_left <= HOLD_LEN;
			else if (hold_left != 0) hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Monitor: every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				report("value with no prediction pending", value, 32'h0);
			end else begin
				want = result_q.pop_front();
				if (value !== want.value) report("value", value, want.value);
				if (phase !== want.phase) report("phase", 32'(phase), 32'(want.phase));
				if (byte_count !== want.count) report("byte_count", byte_count, want.count);
			end
			results_seen++;
		end
	end

	initial begin
		#2400000;
		$display("timeout with %0d bytes taken and %0d results pending", bytes_taken,
			result_q.size());
		$display("tb_detector_pulse_frame_parser_top: errors");
		$finish;
	end

	initial begin
		int unsigned pick;
		int unsigned drain;
		logic [7:0]  bad;

		// Directed frame: idle byte, header extremes, one hit, a pop with no end marker.
		push_byte(8'h00);
		push_byte(BYTE_FRAME_START);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h55);
		push_byte(8'hAA);
		push_byte(8'h01);
		push_byte(8'h80);
		push_byte(8'hFE);
		repeat (4) push_byte(8'hFF);
		repeat (4) push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_pop();
		push_byte(8'h3C);
		push_byte(BYTE_FRAME_START);

		while (bytes_queued < BYTE_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				push_header();
				repeat ($urandom_range(0, 6)) push_hit();
				if ($urandom_range(0, 2) == 0) push_pop();
				push_end_block();
				if ($urandom_range(0, 3) == 0) push_byte(rnd_byte());
			end else if (pick < 86) begin
				push_header();
				repeat ($urandom_range(0, 3)) push_hit();
				push_pop();
				bad = rnd_byte();
				while (bad == BYTE_END_START) bad = rnd_byte();
				push_byte(bad);
				push_byte(rnd_byte());
			end else if (pick < 92) begin
				// Frame cut short; the next bytes land in the middle of its state.
				push_byte(BYTE_FRAME_START);
				repeat ($urandom_range(0, 20)) push_byte(rnd_byte());
			end else begin
				repeat ($urandom_range(1, 6)) push_byte(rnd_byte());
			end
		end

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bytes_taken != bytes_queued) @(posedge clk);
		drain = 0;
		while (result_q.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (result_q.size() != 0) begin
			report("predicted results still pending", 32'(result_q.size()), 32'h0);
		end

		$display("covered %0d bytes and %0d results: %0d frame starts, %0d hits, %0d pops",
			bytes_taken, results_seen, n_frames, n_hits, n_pops);
		$display("%0d end blocks, %0d missing end markers, %0d input stall cycles, %0d mismatches",
			n_ends, n_broken, stall_cycles, mismatches);
		if (mismatches == 0) begin
			$display("tb_detector_pulse_frame_parser_top: clean");
		end else begin
			$display("tb_detector_pulse_frame_parser_top: errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/dpf_pkg.sv
sv/dpf_step.sv
sv/detector_pulse_frame_parser_top.sv
test/tb_detector_pulse_frame_parser_top.sv
